FILE: sv/rgbc_pkg.sv
`default_nettype none

package rgbc_pkg;

	// Widths fixed by the register map and the pixel format.
	localparam int CHAN_BITS     = 8;
	localparam int RGB_BITS      = 3 * CHAN_BITS;
	localparam int DIM_BITS      = 11;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_TOP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BOTTOM = 3'd4;

	// Reset kernel rows: identity kernel with the centre tap at 1.0.
	localparam logic [CFG_DATA_BITS-1:0] COEF_TOP_RST    = 48'd0;
	localparam logic [CFG_DATA_BITS-1:0] COEF_MIDDLE_RST = 48'd16777216;
	localparam logic [CFG_DATA_BITS-1:0] COEF_BOTTOM_RST = 48'd0;

	// Reset image size before clamping to the build limits.
	localparam int DIM_RST = 1024;

	// Input word opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef logic [RGB_BITS-1:0] rgb_t;

	// Window row r, column c; column 0 is the left neighbor.
	typedef rgb_t [2:0][2:0] win_t;

	typedef struct packed {
		logic                 op;
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] out_red;
		logic [CHAN_BITS-1:0] out_green;
		logic [CHAN_BITS-1:0] out_blue;
		logic                 frame_end;
	} result_t;

	// Which border taps of the window lie inside the image.
	typedef struct packed {
		logic row_top;
		logic row_bot;
		logic col_left;
		logic col_right;
	} pad_t;

endpackage

`default_nettype wire

FILE: sv/rgb_conv3x3_clamp.sv
// Streaming 3x3 convolution of RGB pixels with clamping to 0..255.
// Input words arrive on pixel/pixel_valid/pixel_stall in raster order; op
// selects a pixel or a flush tick. Result words leave on result/result_valid/
// result_stall. A word moves when valid is high and stall is low.
// Throughput is one word per cycle while result_stall is low. A result word
// is registered in turn by the line memory read, the window and product
// registers, then the output register. The result for a pixel is produced by
// the input word image_width+1 places later, so after the last pixel the
// source sends flush ticks (one result each) until frame_end comes out.
// Flush ticks sent before the image is complete are taken and dropped.
// The configuration port (cfg_valid/cfg_ready, always ready) sets the image
// size and the three kernel rows of signed fixed-point coefficients; write
// it only while no word is in flight.
// Reset clears the counters, window and pipeline valids and loads a
// 1024x1024 image size (capped to the build limits) and the identity kernel.
// When result_stall is high the output word holds and the pipeline fills;
// pixel_stall rises once no stage can take another word.
`default_nettype none

module rgb_conv3x3_clamp import rgbc_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int COEF_BITS  = 16,
	parameter int COEF_FRAC  = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     pixel_valid,
	output logic                          pixel_stall,
	input  wire pixel_t                   pixel,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output result_t                       result,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = HW + 2;
	localparam int LW = (AW + 1 > DIM_BITS) ? AW + 1 : DIM_BITS;
	localparam int LH = (HW + 1 > DIM_BITS) ? HW + 1 : DIM_BITS;
	localparam int W_RST = (MAX_WIDTH < DIM_RST) ? MAX_WIDTH : DIM_RST;
	localparam int H_RST = (MAX_HEIGHT < DIM_RST) ? MAX_HEIGHT : DIM_RST;

	// Configuration: sizes are stored clamped, minus one.
	logic [AW-1:0]            wm1_q;
	logic [HW-1:0]            hm1_q;
	logic [CFG_DATA_BITS-1:0] coef_top_q, coef_middle_q, coef_bottom_q;
	logic [LW-1:0]            w_ext;
	logic [LH-1:0]            h_ext;
	logic [AW-1:0]            wm1_d;
	logic [HW-1:0]            hm1_d;

	// Position counters.
	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;

	// Accept-side decode.
	logic  drain, take, lag_met, fe;
	logic  in_col_last, out_col_last, out_row_last;
	rgb_t  pix_in;
	pad_t  pad_in;

	// Stage 1: line memory read outstanding.
	logic          v1_q, emit_s1, fe_s1, byp_s1;
	rgb_t          pix_s1, fwd_up_s1, fwd_mid_s1;
	logic [AW-1:0] addr_s1;
	pad_t          pad_s1;
	logic [2*RGB_BITS-1:0] rd_data;
	rgb_t          up_eff, mid_eff;

	// Stage 2: window; stage 3: products.
	logic  v2_q, fe_s2, v3_q;
	win_t  win_q;
	pad_t  pad_s2;

	// Output register.
	logic    result_valid_q;
	result_t result_q, kres;

	// Handshake chain.
	logic rdy_out, rdy1, rdy2, rdy3, move1, mv2, mv3;

	assign cfg_ready = 1'b1;

	always_comb begin
		w_ext = LW'(cfg_data[DIM_BITS-1:0]);
		h_ext = LH'(cfg_data[DIM_BITS-1:0]);
		if (w_ext == '0) begin
			wm1_d = '0;
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			wm1_d = AW'(MAX_WIDTH - 1);
		end else begin
			wm1_d = AW'(w_ext - LW'(1));
		end
		if (h_ext == '0) begin
			hm1_d = '0;
		end else if (h_ext > LH'(MAX_HEIGHT)) begin
			hm1_d = HW'(MAX_HEIGHT - 1);
		end else begin
			hm1_d = HW'(h_ext - LH'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q         <= AW'(W_RST - 1);
			hm1_q         <= HW'(H_RST - 1);
			coef_top_q    <= COEF_TOP_RST;
			coef_middle_q <= COEF_MIDDLE_RST;
			coef_bottom_q <= COEF_BOTTOM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:       wm1_q         <= wm1_d;
				CFG_HEIGHT:      hm1_q         <= hm1_d;
				CFG_COEF_TOP:    coef_top_q    <= cfg_data;
				CFG_COEF_MIDDLE: coef_middle_q <= cfg_data;
				CFG_COEF_BOTTOM: coef_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ready chain from the output register back to the input.
	assign rdy_out     = ~result_valid_q | ~result_stall;
	assign mv3         = v3_q & rdy_out;
	assign rdy3        = ~v3_q | rdy_out;
	assign mv2         = v2_q & rdy3;
	assign rdy2        = ~v2_q | rdy3;
	assign move1       = v1_q & rdy2;
	assign rdy1        = ~v1_q | rdy2;
	assign pixel_stall = ~rdy1;

	// Decode of the accepted word against the counters. Once all rows are
	// in, every word shifts in a zero pixel.
	always_comb begin
		drain        = in_row_q > RW'(hm1_q);
		take         = pixel_valid & rdy1 & (drain | (pixel.op == OP_PIXEL));
		pix_in       = drain ? '0 : {pixel.red, pixel.green, pixel.blue};
		lag_met      = (in_row_q >= RW'(2)) | ((in_row_q == RW'(1)) & (in_col_q != '0));
		in_col_last  = in_col_q >= wm1_q;
		out_col_last = out_col_q >= wm1_q;
		out_row_last = out_row_q >= RW'(hm1_q);
		fe           = lag_met & out_row_last & out_col_last;
		pad_in.row_top   = out_row_q != '0;
		pad_in.row_bot   = ~out_row_last;
		pad_in.col_left  = out_col_q != '0;
		pad_in.col_right = ~out_col_last;
	end

	// Input and output positions; the last result of the image restarts both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (fe) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (lag_met) begin
					if (out_col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + AW'(1);
					end
				end
			end
		end
	end

	rgbc_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (move1),
		.wr_addr (addr_s1),
		.wr_data ({mid_eff, pix_s1})
	);

	// With a one-pixel row the word ahead writes the address being read in
	// the same cycle, so its values are forwarded instead.
	assign up_eff  = byp_s1 ? fwd_up_s1  : rd_data[2*RGB_BITS-1:RGB_BITS];
	assign mid_eff = byp_s1 ? fwd_mid_s1 : rd_data[RGB_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (take) begin
			v1_q <= 1'b1;
		end else if (move1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1     <= pix_in;
			addr_s1    <= in_col_q;
			emit_s1    <= lag_met;
			fe_s1      <= fe;
			pad_s1     <= pad_in;
			byp_s1     <= v1_q & (addr_s1 == in_col_q);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// Window shift; only words that yield a result go on past this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q  <= 1'b0;
			win_q <= '0;
		end else begin
			if (move1) begin
				v2_q <= emit_s1;
			end else if (mv2) begin
				v2_q <= 1'b0;
			end
			if (move1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up_eff;
				win_q[1][2] <= mid_eff;
				win_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			pad_s2 <= pad_s1;
			fe_s2  <= fe_s1;
		end
	end

	rgbc_kernel #(
		.COEF_BITS (COEF_BITS),
		.COEF_FRAC (COEF_FRAC)
	) u_kernel (
		.clk         (clk),
		.load        (mv2),
		.win         (win_q),
		.pad         (pad_s2),
		.frame_end   (fe_s2),
		.coef_top    (coef_top_q),
		.coef_middle (coef_middle_q),
		.coef_bottom (coef_bottom_q),
		.res         (kres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (mv2) begin
			v3_q <= 1'b1;
		end else if (mv3) begin
			v3_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (mv3) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			result_q <= kres;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: sv/rgbc_line_buf.sv
`default_nettype none

// Both line buffers share one memory word: upper line in the high half,
// middle line in the low half. Read data is registered.
module rgbc_line_buf import rgbc_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [2*RGB_BITS-1:0]      rd_data,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [2*RGB_BITS-1:0]      wr_data
);

	logic [2*RGB_BITS-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/rgbc_kernel.sv
`default_nettype none

// Kernel datapath: one registered stage of masked tap products, then the
// per-channel sum, truncation and clamp to 0..255.
module rgbc_kernel import rgbc_pkg::*; #(
	parameter int COEF_BITS = 16,
	parameter int COEF_FRAC = 8
) (
	input  wire logic                     clk,
	input  wire logic                     load,
	input  wire win_t                     win,
	input  wire pad_t                     pad,
	input  wire logic                     frame_end,
	input  wire logic [CFG_DATA_BITS-1:0] coef_top,
	input  wire logic [CFG_DATA_BITS-1:0] coef_middle,
	input  wire logic [CFG_DATA_BITS-1:0] coef_bottom,
	output result_t                       res
);

	localparam int PW = COEF_BITS + CHAN_BITS + 1;
	localparam int SW = PW + 4;
	localparam int CX = (3 * COEF_BITS > CFG_DATA_BITS) ? 3 * COEF_BITS : CFG_DATA_BITS;

	logic [CX-1:0]          row_ext [3];
	logic signed [PW-1:0]   prod_d  [3][3][3];
	logic signed [PW-1:0]   prod_s3 [3][3][3];
	logic                   fe_s3;
	logic signed [SW-1:0]   sum     [3];

	function automatic logic [CHAN_BITS-1:0] clamp(input logic signed [SW-1:0] s);
		logic [SW-1:0] sh;
		sh = SW'(unsigned'(s) >> COEF_FRAC);
		if (s[SW-1]) begin
			return '0;
		end else if (|sh[SW-1:CHAN_BITS]) begin
			return '1;
		end else begin
			return sh[CHAN_BITS-1:0];
		end
	endfunction

	// Tap products; taps outside the image contribute nothing.
	always_comb begin
		logic                        use_tap;
		logic signed [CHAN_BITS:0]   pv;
		logic signed [COEF_BITS-1:0] kv;
		row_ext[0] = CX'(coef_top);
		row_ext[1] = CX'(coef_middle);
		row_ext[2] = CX'(coef_bottom);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				use_tap = 1'b1;
				if (r == 0 && !pad.row_top)   use_tap = 1'b0;
				if (r == 2 && !pad.row_bot)   use_tap = 1'b0;
				if (c == 0 && !pad.col_left)  use_tap = 1'b0;
				if (c == 2 && !pad.col_right) use_tap = 1'b0;
				kv = $signed(row_ext[r][c*COEF_BITS +: COEF_BITS]);
				for (int ch = 0; ch < 3; ch++) begin
					pv = $signed({1'b0, win[r][c][(2-ch)*CHAN_BITS +: CHAN_BITS]});
					if (use_tap) begin
						prod_d[r][c][ch] = pv * kv;
					end else begin
						prod_d[r][c][ch] = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s3 <= prod_d;
			fe_s3   <= frame_end;
		end
	end

	// Nine-term sum per channel.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sum[ch] = sum[ch] + SW'(prod_s3[r][c][ch]);
				end
			end
		end
	end

	always_comb begin
		res.out_red   = clamp(sum[0]);
		res.out_green = clamp(sum[1]);
		res.out_blue  = clamp(sum[2]);
		res.frame_end = fe_s3;
	end

endmodule

`default_nettype wire

FILE: verif/tb_rgb_conv3x3_clamp.sv
`timescale 1ns / 100ps

module tb_rgb_conv3x3_clamp;
	import rgbc_pkg::*;

	// Build limits of the instance under test and run bounds.
	localparam int unsigned FRAME_MAX_W   = 1024;
	localparam int unsigned FRAME_MAX_H   = 1024;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned RANDOM_WORDS  = 500;

	logic                     clk;
	logic                     arst_n;
	logic                     pixel_valid;
	logic                     pixel_stall;
	pixel_t                   pixel;
	logic                     result_valid;
	logic                     result_stall;
	result_t                  result;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// Shadow of the register file and the values a test wants to load next.
	logic [CFG_DATA_BITS-1:0] reg_shadow [5];
	logic [CFG_DATA_BITS-1:0] cfg_plan [5];

	// Predictor copy of the line stores, the window and the raster counters.
	rgb_t        upper_mem [FRAME_MAX_W];
	rgb_t        middle_mem [FRAME_MAX_W];
	rgb_t        conv_win [3][3];
	int unsigned in_col;
	int unsigned in_row;
	int unsigned out_col;
	int unsigned out_row;

	// Filtered pixels still owed by the block, oldest first.
	result_t filtered_q [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	int unsigned gap_max = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_cycles = 0;

	rgb_conv3x3_clamp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Free-running clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver stall pattern: random runs, or one long hold when a test asks.
	initial begin : stall_pattern
		int unsigned run_left;
		bit          stalling;
		run_left = 0;
		stalling = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(99) < stall_pct);
					run_left = stalling ? $urandom_range(1, 8) : $urandom_range(1, 24);
				end
				run_left--;
				result_stall <= stalling;
			end
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < 50)
			$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (filtered_q.size() == 0) begin
				report_mismatch("result word with none expected", 32'(result), 0);
			end else begin
				want = filtered_q.pop_front();
				if (result.out_red !== want.out_red)
					report_mismatch("out_red", 32'(result.out_red), 32'(want.out_red));
				if (result.out_green !== want.out_green)
					report_mismatch("out_green", 32'(result.out_green), 32'(want.out_green));
				if (result.out_blue !== want.out_blue)
					report_mismatch("out_blue", 32'(result.out_blue), 32'(want.out_blue));
				if (result.frame_end !== want.frame_end)
					report_mismatch("frame_end", 32'(result.frame_end), 32'(want.frame_end));
			end
		end
	end

	// Register value of a size as the block uses it, held to 1..limit.
	function automatic int unsigned clamp_dim(input logic [CFG_DATA_BITS-1:0] v,
			input int unsigned limit);
		int unsigned d;
		d = 32'(v[DIM_BITS-1:0]);
		if (d < 1) d = 1;
		if (d > limit) d = limit;
		return d;
	endfunction

	function automatic void step_pos(inout int unsigned col, inout int unsigned row,
			input int unsigned w);
		if (col + 1 >= w) begin
			col = 0;
			row = row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// Advance the predictor by one accepted word; returns 1 when it yields a
	// filtered pixel.
	function automatic bit conv_predict(input pixel_t wd, output result_t res);
		int unsigned              w;
		int unsigned              h;
		int unsigned              ci;
		rgb_t                     px;
		bit                       lag;
		logic [CFG_DATA_BITS-1:0] krow [3];
		longint                   acc [3];
		longint                   q;
		logic signed [15:0]       tap;
		logic [CHAN_BITS-1:0]     chan;
		logic [CHAN_BITS-1:0]     outv [3];
		res = '0;
		w = clamp_dim(reg_shadow[CFG_WIDTH], FRAME_MAX_W);
		h = clamp_dim(reg_shadow[CFG_HEIGHT], FRAME_MAX_H);

		// Once all rows are in, every word pushes a zero pixel; a flush
		// tick before that is dropped.
		if (in_row >= h)
			px = '0;
		else if (wd.op == OP_PIXEL)
			px = {wd.red, wd.green, wd.blue};
		else
			return 1'b0;

		ci = (in_col < FRAME_MAX_W) ? in_col : FRAME_MAX_W - 1;
		for (int r = 0; r < 3; r++) begin
			conv_win[r][0] = conv_win[r][1];
			conv_win[r][1] = conv_win[r][2];
		end
		conv_win[0][2] = upper_mem[ci];
		conv_win[1][2] = middle_mem[ci];
		conv_win[2][2] = px;
		upper_mem[ci] = middle_mem[ci];
		middle_mem[ci] = px;

		lag = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		step_pos(in_col, in_row, w);
		if (!lag)
			return 1'b0;

		// Sum the taps that fall inside the image; outside neighbors are zero.
		krow[0] = reg_shadow[CFG_COEF_TOP];
		krow[1] = reg_shadow[CFG_COEF_MIDDLE];
		krow[2] = reg_shadow[CFG_COEF_BOTTOM];
		for (int ch = 0; ch < 3; ch++)
			acc[ch] = 0;
		for (int r = 0; r < 3; r++) begin
			if (!(r == 0 && out_row < 1) && !(r == 2 && out_row + 1 >= h)) begin
				for (int c = 0; c < 3; c++) begin
					if (!(c == 0 && out_col < 1) && !(c == 2 && out_col + 1 >= w)) begin
						tap = krow[r][16*c +: 16];
						for (int ch = 0; ch < 3; ch++) begin
							chan = conv_win[r][c][16 - 8*ch +: 8];
							acc[ch] += longint'(chan) * longint'(tap);
						end
					end
				end
			end
		end

		// Drop the fraction, then hold each channel to 0..255.
		for (int ch = 0; ch < 3; ch++) begin
			if (acc[ch] < 0) begin
				outv[ch] = '0;
			end else begin
				q = acc[ch] >>> 8;
				outv[ch] = (q > 255) ? 8'hFF : 8'(q);
			end
		end
		res.out_red = outv[0];
		res.out_green = outv[1];
		res.out_blue = outv[2];

		if (out_row + 1 >= h && out_col + 1 >= w) begin
			res.frame_end = 1'b1;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			res.frame_end = 1'b0;
			step_pos(out_col, out_row, w);
		end
		return 1'b1;
	endfunction

	// Offer one word, wait for it to be taken, then record what it should
	// produce. Between bursts the sender goes quiet for a random gap.
	task automatic send_word(input pixel_t wd, output bit last);
		result_t     want;
		int unsigned gap;
		pixel <= wd;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall !== 1'b0)
			@(posedge clk);
		last = 1'b0;
		if (conv_predict(wd, want)) begin
			filtered_q.push_back(want);
			last = want.frame_end;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 32);
			gap = $urandom_range(gap_max, 0);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and let every owed result come out, plus pipeline slack.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the selected registers from cfg_plan, back to back.
	task automatic program_regs(input logic [4:0] sel);
		for (int i = CFG_WIDTH; i <= CFG_COEF_BOTTOM; i++) begin
			if (sel[i]) begin
				cfg_index <= CFG_IDX_BITS'(i);
				cfg_data <= cfg_plan[i];
				cfg_valid <= 1'b1;
				@(posedge clk);
				while (cfg_ready !== 1'b1)
					@(posedge clk);
				reg_shadow[i] = cfg_plan[i];
			end
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic pixel_t rand_pixel(input logic op);
		pixel_t               wd;
		logic [CHAN_BITS-1:0] ch [3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(7))
				0: ch[i] = '0;
				1: ch[i] = '1;
				default: ch[i] = CHAN_BITS'($urandom);
			endcase
		end
		wd.op = op;
		wd.red = ch[0];
		wd.green = ch[1];
		wd.blue = ch[2];
		return wd;
	endfunction

	// Kernel taps lean toward small values so results are not all saturated.
	function automatic logic [CFG_DATA_BITS-1:0] rand_row();
		logic [15:0] t [3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(9))
				0: t[i] = 16'h7FFF;
				1: t[i] = 16'h8000;
				2: t[i] = 16'($urandom);
				3: t[i] = 16'h0000;
				default: t[i] = 16'(int'($urandom_range(160)) - 64);
			endcase
		end
		return {t[2], t[1], t[0]};
	endfunction

	// Feed pixels until the image is in, then drain words until frame_end.
	// Stray flush ticks go in before the end; drain words mix in pixels.
	task automatic stream_frame(input int unsigned noise_pct, input int unsigned drain_pix_pct);
		pixel_t wd;
		bit     last;
		bit     loaded;
		last = 1'b0;
		while (!last) begin
			loaded = (in_row >= clamp_dim(reg_shadow[CFG_HEIGHT], FRAME_MAX_H));
			if (loaded)
				wd = rand_pixel(($urandom_range(99) < drain_pix_pct) ? OP_PIXEL : OP_FLUSH);
			else
				wd = rand_pixel(($urandom_range(99) < noise_pct) ? OP_FLUSH : OP_PIXEL);
			if (loaded || wd.op == OP_PIXEL)
				words_sent++;
			send_word(wd, last);
		end
	endtask

	// A two-row image with only the sizes written checks the reset kernel.
	task automatic test_reset_kernel_wide();
		logic [4:0] sel;
		sel = '0;
		sel[CFG_WIDTH] = 1'b1;
		sel[CFG_HEIGHT] = 1'b1;
		cfg_plan[CFG_WIDTH] = 48'd40;
		cfg_plan[CFG_HEIGHT] = 48'd2;
		program_regs(sel);
		gap_max = 2;
		stall_pct = 20;
		stream_frame(0, 50);
		wait_idle();
	endtask

	// Saturating, strongly negative and half-weight kernels on a 3x3 image.
	task automatic test_kernel_extremes();
		cfg_plan[CFG_WIDTH] = 48'd3;
		cfg_plan[CFG_HEIGHT] = 48'd3;
		cfg_plan[CFG_COEF_TOP] = {3{16'h7FFF}};
		cfg_plan[CFG_COEF_MIDDLE] = {3{16'h7FFF}};
		cfg_plan[CFG_COEF_BOTTOM] = {3{16'h7FFF}};
		program_regs('1);
		gap_max = 0;
		stall_pct = 0;
		stream_frame(0, 50);
		wait_idle();

		cfg_plan[CFG_COEF_TOP] = {3{16'h8000}};
		cfg_plan[CFG_COEF_MIDDLE] = {16'h8000, 16'h0100, 16'h8000};
		cfg_plan[CFG_COEF_BOTTOM] = {3{16'h8000}};
		program_regs('1);
		gap_max = 3;
		stall_pct = 40;
		stream_frame(30, 50);
		wait_idle();

		cfg_plan[CFG_COEF_TOP] = {3{16'h0080}};
		cfg_plan[CFG_COEF_MIDDLE] = {16'h0001, 16'h0080, 16'hFFFF};
		cfg_plan[CFG_COEF_BOTTOM] = {3{16'h0080}};
		program_regs('1);
		stream_frame(10, 50);
		wait_idle();
	endtask

	// Zero sizes clamp to one; single columns and rows, back-to-back images,
	// and the tallest image.
	task automatic test_degenerate_sizes();
		logic [4:0] sel;
		cfg_plan[CFG_WIDTH] = 48'd0;
		cfg_plan[CFG_HEIGHT] = 48'd0;
		cfg_plan[CFG_COEF_TOP] = rand_row();
		cfg_plan[CFG_COEF_MIDDLE] = rand_row();
		cfg_plan[CFG_COEF_BOTTOM] = rand_row();
		program_regs('1);
		gap_max = 2;
		stall_pct = 30;
		stream_frame(40, 50);
		wait_idle();

		sel = '0;
		sel[CFG_WIDTH] = 1'b1;
		sel[CFG_HEIGHT] = 1'b1;
		cfg_plan[CFG_WIDTH] = 48'd1;
		cfg_plan[CFG_HEIGHT] = 48'd3;
		program_regs(sel);
		stream_frame(10, 50);
		wait_idle();

		cfg_plan[CFG_WIDTH] = 48'd3;
		cfg_plan[CFG_HEIGHT] = 48'd1;
		program_regs(sel);
		stream_frame(10, 50);
		stream_frame(10, 50);
		wait_idle();

		cfg_plan[CFG_WIDTH] = 48'd1;
		cfg_plan[CFG_HEIGHT] = 48'd2047;
		program_regs(sel);
		gap_max = 0;
		stall_pct = 10;
		stream_frame(0, 50);
		wait_idle();
	endtask

	// Pause part way through an image, shrink it and change the kernel,
	// then finish it under the new sizes.
	task automatic test_resize_mid_frame();
		logic [4:0] sel;
		pixel_t     wd;
		bit         last;
		cfg_plan[CFG_WIDTH] = 48'd6;
		cfg_plan[CFG_HEIGHT] = 48'd5;
		cfg_plan[CFG_COEF_TOP] = rand_row();
		cfg_plan[CFG_COEF_MIDDLE] = rand_row();
		cfg_plan[CFG_COEF_BOTTOM] = rand_row();
		program_regs('1);
		gap_max = 3;
		stall_pct = 30;
		for (int n = 0; n < 15; n++) begin
			wd = rand_pixel(OP_PIXEL);
			send_word(wd, last);
		end
		wait_idle();

		sel = '0;
		sel[CFG_WIDTH] = 1'b1;
		sel[CFG_HEIGHT] = 1'b1;
		sel[CFG_COEF_MIDDLE] = 1'b1;
		cfg_plan[CFG_WIDTH] = 48'd4;
		cfg_plan[CFG_HEIGHT] = 48'd4;
		cfg_plan[CFG_COEF_MIDDLE] = rand_row();
		program_regs(sel);
		stream_frame(5, 50);
		wait_idle();
	endtask

	// Hold the output off for a long stretch while the sender keeps going,
	// so the pipeline fills and pushes back on the input.
	task automatic test_backpressure();
		cfg_plan[CFG_WIDTH] = 48'd8;
		cfg_plan[CFG_HEIGHT] = 48'd6;
		cfg_plan[CFG_COEF_TOP] = rand_row();
		cfg_plan[CFG_COEF_MIDDLE] = rand_row();
		cfg_plan[CFG_COEF_BOTTOM] = rand_row();
		program_regs('1);
		gap_max = 0;
		stall_pct = 0;
		hold_cycles = 300;
		stream_frame(0, 30);
		wait_idle();
	endtask

	// Random small images with random kernels and idle patterns.
	task automatic test_random_frames();
		int unsigned start;
		int unsigned w;
		int unsigned h;
		logic [4:0]  sel;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			case ($urandom_range(7))
				0: w = 0;
				1: w = $urandom_range(24, 64);
				default: w = $urandom_range(1, 10);
			endcase
			case ($urandom_range(7))
				0: h = 0;
				1: h = $urandom_range(10, 20);
				default: h = $urandom_range(1, 6);
			endcase
			cfg_plan[CFG_WIDTH] = {16'($urandom), 21'($urandom), 11'(w)};
			cfg_plan[CFG_HEIGHT] = {16'($urandom), 21'($urandom), 11'(h)};
			cfg_plan[CFG_COEF_TOP] = rand_row();
			cfg_plan[CFG_COEF_MIDDLE] = rand_row();
			cfg_plan[CFG_COEF_BOTTOM] = rand_row();
			sel = ($urandom_range(3) == 0) ? 5'($urandom) : '1;
			program_regs(sel);
			case ($urandom_range(3))
				0: gap_max = 0;
				1: gap_max = 1;
				2: gap_max = 4;
				default: gap_max = 10;
			endcase
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			repeat ($urandom_range(1, 2)) stream_frame(5, 40);
			wait_idle();
		end
	endtask

	// Reset, run the tests in turn, then give the verdict.
	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;

		reg_shadow[CFG_WIDTH] = CFG_DATA_BITS'(DIM_RST);
		reg_shadow[CFG_HEIGHT] = CFG_DATA_BITS'(DIM_RST);
		reg_shadow[CFG_COEF_TOP] = COEF_TOP_RST;
		reg_shadow[CFG_COEF_MIDDLE] = COEF_MIDDLE_RST;
		reg_shadow[CFG_COEF_BOTTOM] = COEF_BOTTOM_RST;
		for (int i = 0; i < 5; i++)
			cfg_plan[i] = '0;
		for (int i = 0; i < FRAME_MAX_W; i++) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				conv_win[r][c] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_kernel_wide();
		test_kernel_extremes();
		test_degenerate_sizes();
		test_resize_mid_frame();
		test_backpressure();
		test_random_frames();

		wait_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: rgb_conv3x3_clamp.f
sv/rgbc_pkg.sv
sv/rgbc_line_buf.sv
sv/rgbc_kernel.sv
sv/rgb_conv3x3_clamp.sv
verif/tb_rgb_conv3x3_clamp.sv
